### hw/rtl/nthd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nthd_pkg
// Shared constants and types of the name-to-id dictionary.
// ----------------------------------------------------------------------------
package nthd_pkg;
    localparam int TABLE_SLOTS   = 1024;
    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_WORDS     = (MAX_KEY_BYTES + 7) / 8;
    localparam int SLOT_W        = $clog2(TABLE_SLOTS);
    localparam int LEN_W         = $clog2(MAX_KEY_BYTES + 1);
    localparam int ID_W          = 10;
    localparam int CNT_W         = 11;
    localparam int KEY_W         = KEY_WORDS * 64;

    localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [63:0]      hash;
        logic             too_long;
    } key_req_t;
endpackage
`default_nettype wire

### hw/rtl/name_to_id_hash_dictionary_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// name_to_id_hash_dictionary_core
// FNV-1a hashed name-to-id dictionary with a linear-probing slot store.
// ----------------------------------------------------------------------------
// Each byte runs through the four-step split 64-bit multiply before the next byte is accepted.
// A final byte holds the hasher in H_OUT while the table probes; each probed slot
// takes a registered memory read and a compare, and T_DONE then raises the result item.
// An over-long name skips probing; a lookup waits for the previous result item.
// Reset clears the control state, then a pass over all 1024 slots clears used bits;
// no lookup starts until that pass is done. load_limit resets to 716.
module name_to_id_hash_dictionary_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_key_byte,
    input  wire logic        s_key_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [9:0]       m_vertex_id,
    output logic             m_is_new,
    output logic [1:0]       m_status
);
    logic [nthd_pkg::CNT_W-1:0] load_limit_reg;
    logic                        req_valid;
    logic                        req_ready;
    nthd_pkg::key_req_t          req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_limit_reg <= 11'd716;
        end else if (cfg_wr_en) begin
            load_limit_reg <= cfg_wr_data;
        end
    end

    nthd_hash u_hash (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_key_byte(s_key_byte), .s_key_last(s_key_last),
        .req_valid(req_valid), .req_ready(req_ready), .req(req)
    );

    nthd_table u_table (
        .aclk(aclk), .aresetn(aresetn), .load_limit(load_limit_reg),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_vertex_id(m_vertex_id), .m_is_new(m_is_new), .m_status(m_status)
    );
endmodule
`default_nettype wire

### hw/rtl/nthd_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nthd_hash
// Folds key bytes into FNV-1a and packs them into the key buffer.
// The 64x64 multiply is split into three 32x32 partial products over cycles.
// ----------------------------------------------------------------------------
module nthd_hash (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_key_byte,
    input  wire logic               s_key_last,
    output logic                    req_valid,
    input  wire logic               req_ready,
    output nthd_pkg::key_req_t      req
);
    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_M0   = 3'd1;
    localparam logic [2:0] H_M1   = 3'd2;
    localparam logic [2:0] H_M2   = 3'd3;
    localparam logic [2:0] H_SUM  = 3'd4;
    localparam logic [2:0] H_OUT  = 3'd5;

    logic [2:0]                      st_reg;
    logic [63:0]                     hash_reg;
    logic [63:0]                     x_reg;
    logic [63:0]                     ll_reg;
    logic [31:0]                     lh_reg;
    logic [31:0]                     hl_reg;
    logic [nthd_pkg::KEY_W-1:0]      key_reg;
    logic [nthd_pkg::LEN_W-1:0]      len_reg;
    logic                            long_reg;
    logic                            last_reg;
    logic [63:0]                     prod;
    logic [$clog2(nthd_pkg::KEY_W)-1:0] bitpos;

    assign s_ready   = (st_reg == H_IDLE);
    assign req_valid = (st_reg == H_OUT);
    assign req.key      = key_reg;
    assign req.len      = len_reg;
    assign req.hash     = hash_reg;
    assign req.too_long = long_reg;
    assign bitpos = {len_reg[nthd_pkg::LEN_W-2:0], 3'b000};
    assign prod   = ll_reg + {lh_reg, 32'd0} + {hl_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= H_IDLE;
            hash_reg <= nthd_pkg::FNV_BASIS;
            len_reg  <= '0;
            long_reg <= 1'b0;
        end else begin
            case (st_reg)
                H_IDLE: if (s_valid) begin
                    x_reg    <= hash_reg ^ {56'd0, s_key_byte};
                    last_reg <= s_key_last;
                    if (len_reg < nthd_pkg::LEN_W'(nthd_pkg::MAX_KEY_BYTES)) begin
                        key_reg[bitpos +: 8] <= s_key_byte;
                        len_reg <= len_reg + 1'b1;
                    end else begin
                        long_reg <= 1'b1;
                    end
                    st_reg <= H_M0;
                end
                H_M0: begin
                    ll_reg <= 64'(x_reg[31:0] * nthd_pkg::FNV_PRIME[31:0]);
                    st_reg <= H_M1;
                end
                H_M1: begin
                    lh_reg <= 32'(x_reg[31:0] * nthd_pkg::FNV_PRIME[63:32]);
                    st_reg <= H_M2;
                end
                H_M2: begin
                    hl_reg <= 32'(x_reg[63:32] * nthd_pkg::FNV_PRIME[31:0]);
                    st_reg <= H_SUM;
                end
                H_SUM: begin
                    hash_reg <= prod;
                    st_reg   <= last_reg ? H_OUT : H_IDLE;
                end
                H_OUT: if (req_ready) begin
                    hash_reg <= nthd_pkg::FNV_BASIS;
                    len_reg  <= '0;
                    long_reg <= 1'b0;
                    st_reg   <= H_IDLE;
                end
                default: st_reg <= H_IDLE;
            endcase
        end
    end

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= nthd_pkg::LEN_W'(nthd_pkg::MAX_KEY_BYTES))
        else $error("key length beyond buffer");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !req_valid) else $error("accept during request");
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid && !req_ready |=> req_valid && $stable(hash_reg))
        else $error("request dropped");
endmodule
`default_nettype wire

### hw/rtl/nthd_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nthd_table
// Slot store with linear probing; clears the used bits after reset.
// ----------------------------------------------------------------------------
module nthd_table (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [nthd_pkg::CNT_W-1:0] load_limit,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire nthd_pkg::key_req_t        req,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [nthd_pkg::ID_W-1:0]      m_vertex_id,
    output logic                           m_is_new,
    output logic [1:0]                     m_status
);
    localparam int ENT_W = nthd_pkg::KEY_W + nthd_pkg::LEN_W + nthd_pkg::ID_W + 1;

    localparam logic [2:0] T_CLEAR = 3'd0;
    localparam logic [2:0] T_IDLE  = 3'd1;
    localparam logic [2:0] T_READ  = 3'd2;
    localparam logic [2:0] T_CMP   = 3'd3;
    localparam logic [2:0] T_DONE  = 3'd4;

    logic [ENT_W-1:0] mem [nthd_pkg::TABLE_SLOTS];
    logic [ENT_W-1:0] rd_reg;
    logic [ENT_W-1:0] wr_data;
    logic             wr_en;
    logic [nthd_pkg::SLOT_W-1:0] wr_addr;

    logic [2:0]                    st_reg;
    logic [nthd_pkg::SLOT_W-1:0]   slot_reg;
    logic [nthd_pkg::SLOT_W:0]     probes_reg;
    logic [nthd_pkg::CNT_W-1:0]    count_reg;
    logic [nthd_pkg::KEY_W-1:0]    kmask;
    logic                          used;
    logic [nthd_pkg::LEN_W-1:0]    s_len;
    logic [nthd_pkg::KEY_W-1:0]    s_key;
    logic [nthd_pkg::ID_W-1:0]     s_id;
    logic                          match;

    assign {used, s_len, s_id, s_key} = rd_reg;
    always_comb begin
        for (int i = 0; i < nthd_pkg::KEY_W; i++)
            kmask[i] = (i < 8 * int'(req.len));
    end
    assign match = (s_len == req.len) && (((s_key ^ req.key) & kmask) == '0);
    assign req_ready = (st_reg == T_DONE);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = {1'b1, req.len, nthd_pkg::ID_W'(count_reg), req.key};
        if (st_reg == T_CLEAR) begin
            wr_en   = 1'b1;
            wr_data = '0;
        end else if (st_reg == T_CMP && !req.too_long && !used
                     && count_reg < load_limit) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= T_CLEAR;
            slot_reg  <= '0;
            count_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (st_reg)
                T_CLEAR: begin
                    slot_reg <= slot_reg + 1'b1;
                    if (slot_reg == nthd_pkg::SLOT_W'(nthd_pkg::TABLE_SLOTS - 1))
                        st_reg <= T_IDLE;
                end
                T_IDLE: if (req_valid && !m_valid) begin
                    slot_reg   <= req.hash[nthd_pkg::SLOT_W-1:0];
                    probes_reg <= '0;
                    if (req.too_long) begin
                        m_vertex_id <= '0;
                        m_is_new    <= 1'b0;
                        m_status    <= nthd_pkg::ST_TOO_LONG;
                        st_reg      <= T_DONE;
                    end else begin
                        st_reg <= T_READ;
                    end
                end
                T_READ: st_reg <= T_CMP;
                T_CMP: begin
                    st_reg <= T_DONE;
                    if (!used) begin
                        if (count_reg < load_limit) begin
                            m_vertex_id <= nthd_pkg::ID_W'(count_reg);
                            m_is_new    <= 1'b1;
                            m_status    <= nthd_pkg::ST_OK;
                            count_reg   <= count_reg + 1'b1;
                        end else begin
                            m_vertex_id <= '0;
                            m_is_new    <= 1'b0;
                            m_status    <= nthd_pkg::ST_FULL;
                        end
                    end else if (match) begin
                        m_vertex_id <= s_id;
                        m_is_new    <= 1'b0;
                        m_status    <= nthd_pkg::ST_OK;
                    end else if (probes_reg ==
                                 (nthd_pkg::SLOT_W+1)'(nthd_pkg::TABLE_SLOTS - 1)) begin
                        m_vertex_id <= '0;
                        m_is_new    <= 1'b0;
                        m_status    <= nthd_pkg::ST_FULL;
                    end else begin
                        slot_reg   <= slot_reg + 1'b1;
                        probes_reg <= probes_reg + 1'b1;
                        st_reg     <= T_READ;
                    end
                end
                T_DONE: begin
                    m_valid <= 1'b1;
                    st_reg  <= T_IDLE;
                end
                default: st_reg <= T_IDLE;
            endcase
        end
    end

    a_new_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_new |-> m_status == nthd_pkg::ST_OK)
        else $error("new item with error status");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != nthd_pkg::ST_OK |-> m_vertex_id == '0)
        else $error("error item with id");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> $past(wr_en) && $past(st_reg) == T_CMP)
        else $error("count moved without insert");
endmodule
`default_nettype wire
